// File: hw/rtl/rt_priority_ranker_defines.svh
// ---------------------------------------------------------------------------
// rt_priority_ranker_defines
// Assertion macros used by the rank engine checker.
// ---------------------------------------------------------------------------
`ifndef RT_PRIORITY_RANKER_DEFINES_SVH
`define RT_PRIORITY_RANKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RPR_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RPR_ASSERT_NXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rpr_pkg.sv
// ---------------------------------------------------------------------------
// rpr_pkg
// Types, register indexes and policy codes of the priority ranker.
// ---------------------------------------------------------------------------
package rpr_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int KEY_WIDTH_DEF = 32;

  localparam int FIELD_W    = 32;
  localparam int POLICY_W   = 2;
  localparam int LEVELS_W   = 9;
  localparam int IDLE_W     = 8;
  localparam int TIDX_W     = 4;
  localparam int PRIO_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 2'd2;

  // policy codes
  localparam logic [POLICY_W-1:0] POL_RM   = 2'd0;
  localparam logic [POLICY_W-1:0] POL_DM   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd2;
  localparam logic [POLICY_W-1:0] POL_EDF  = 2'd3;

  localparam logic [POLICY_W-1:0] POLICY_RST = POL_RM;
  localparam logic [LEVELS_W-1:0] LEVELS_RST = 9'd8;
  localparam logic [IDLE_W-1:0]   IDLE_RST   = 8'd0;

  typedef struct packed {
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] relative_deadline;
    logic [FIELD_W-1:0] job_seq;
    logic [FIELD_W-1:0] deadline_tick;
    logic               task_ready;
    logic               last_task;
  } task_rec_t;

  typedef struct packed {
    logic [TIDX_W-1:0] task_index;
    logic [PRIO_W-1:0] priority_res;
    logic              last_result;
  } rank_res_t;

  // settings that the rank engine captures when a set closes
  typedef struct packed {
    logic                dynamic;
    logic [LEVELS_W-1:0] levels;
    logic [IDLE_W-1:0]   idle;
  } rank_cfg_t;

endpackage

// File: hw/rtl/rpr_ram.sv
// ---------------------------------------------------------------------------
// rpr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rpr_ranker.sv
// ---------------------------------------------------------------------------
// rpr_ranker
// Rank sequencer: for each stored task, sweep the task RAM, count the tasks
// that beat it, map the rank to a priority and load the result register.
// ---------------------------------------------------------------------------
module rpr_ranker import rpr_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  localparam int IDX_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int CNT_W    = $clog2(MAX_TASKS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [CNT_W-1:0]   n_tasks,
  input  rank_cfg_t          cfg_in,
  output logic               busy,
  output logic [IDX_W-1:0]   rd_addr,
  input  logic [KEY_WIDTH:0] rd_data,
  output logic               res_valid,
  input  logic               res_stall,
  output rank_res_t          res
);

  localparam int P_W = ((CNT_W > LEVELS_W) ? CNT_W : LEVELS_W) + 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_KEYI  = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]           state, state_next;
  logic [IDX_W-1:0]     i, jd, last_idx;
  logic [CNT_W-1:0]     n_r, rank, rank_eff;
  rank_cfg_t            cfg_r;
  logic [KEY_WIDTH-1:0] key_i, key_j;
  logic                 rdy_i, rdy_j;
  logic                 hit, can_load, res_valid_next;
  logic signed [P_W-1:0] p_s, floor_s, clamp_s;
  logic [PRIO_W-1:0]    prio;

  assign busy  = (state != ST_IDLE);
  assign key_j = rd_data[KEY_WIDTH-1:0];
  assign rdy_j = rd_data[KEY_WIDTH];

  always_comb begin
    unique case (state)
      ST_FETCH: rd_addr = i;
      ST_KEYI:  rd_addr = jd;
      default:  rd_addr = jd + IDX_W'(1);
    endcase
  end

  // task j beats task i: smaller key, or equal key at a lower index; under a dynamic policy only a ready task j counts
  assign hit = (jd != i) && !(cfg_r.dynamic && !rdy_j) &&
               ((key_j < key_i) || ((key_j == key_i) && (jd < i)));

  // priority = levels - 2 - rank (n if task not ready, dynamic policy), signed, floored at idle + 1, capped at 255
  always_comb begin
    rank_eff = (cfg_r.dynamic && !rdy_i) ? n_r : rank;
    p_s      = $signed(P_W'(cfg_r.levels)) - $signed(P_W'(2)) - $signed(P_W'(rank_eff));
    floor_s  = $signed(P_W'(cfg_r.idle)) + $signed(P_W'(1));
    clamp_s  = (p_s < floor_s) ? floor_s : p_s;
    prio     = (clamp_s > $signed(P_W'(255))) ? {PRIO_W{1'b1}} : clamp_s[PRIO_W-1:0];
  end

  assign can_load = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_KEYI;
      ST_KEYI:  state_next = ST_SWEEP;
      ST_SWEEP: if (jd == last_idx) state_next = ST_EMIT;
      ST_EMIT: begin
        if (can_load) begin
          state_next = (i == last_idx) ? ST_IDLE : ST_FETCH;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (state == ST_EMIT && can_load) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      i         <= '0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      if (state == ST_IDLE && start) begin
        i <= '0;
      end else if (state == ST_EMIT && can_load) begin
        i <= i + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      n_r      <= n_tasks;
      last_idx <= IDX_W'(n_tasks - CNT_W'(1));
      cfg_r    <= cfg_in;
    end
    unique case (state)
      ST_FETCH: jd <= '0;
      ST_KEYI: begin
        key_i <= key_j;
        rdy_i <= rdy_j;
        rank  <= '0;
      end
      ST_SWEEP: begin
        jd   <= jd + IDX_W'(1);
        rank <= rank + CNT_W'(hit);
      end
      default: ;
    endcase
    if (state == ST_EMIT && can_load) begin
      res.task_index   <= TIDX_W'(i);
      res.priority_res <= prio;
      res.last_result  <= (i == last_idx);
    end
  end

endmodule

// File: hw/rtl/rt_priority_ranker.sv
// ---------------------------------------------------------------------------
// rt_priority_ranker
// Rank-based RM / DM / FIFO / EDF priority assignment over a stored task set.
//
//   channel   direction  handshake                 payload
//   task      in         task_valid / task_stall   task_rec  (task_rec_t)
//   rank      out        rank_valid / rank_stall   rank_res  (rank_res_t)
//   cfg       in         cfg_we                    cfg_index, cfg_data
//
// A record that does not close the set is taken whenever task_stall is low.
// A closing record starts the rank pass: each of the n tasks goes through
// fetch, key capture, an n-entry sweep and result load; the sweep reads
// one entry at a time through the single read port of the task RAM.
// task_stall stays high for the whole pass; a stall on rank holds the pass.
// Reset (synchronous) clears the record count, sequencer and config registers;
// the task RAM needs no clearing since only loaded entries are read.
// ---------------------------------------------------------------------------
module rt_priority_ranker import rpr_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  task_valid,
  output logic                  task_stall,
  input  task_rec_t             task_rec,
  output logic                  rank_valid,
  input  logic                  rank_stall,
  output rank_res_t             rank_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [POLICY_W-1:0]  policy;
  logic [LEVELS_W-1:0]  priority_levels;
  logic [IDLE_W-1:0]    idle_priority;

  logic [CNT_W-1:0]     task_count, task_count_next, n_tasks;
  logic                 accept, room, wr_en, start, busy;
  logic [FIELD_W-1:0]   key_sel;
  logic [KEY_WIDTH-1:0] key;
  logic [IDX_W-1:0]     rd_addr;
  logic [KEY_WIDTH:0]   rd_data;
  rank_cfg_t            rank_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy          <= POLICY_RST;
      priority_levels <= LEVELS_RST;
      idle_priority   <= IDLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY: policy          <= cfg_data[POLICY_W-1:0];
        REG_LEVELS: priority_levels <= cfg_data[LEVELS_W-1:0];
        REG_IDLE:   idle_priority   <= cfg_data[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (policy)
      POL_RM:   key_sel = task_rec.period;
      POL_DM:   key_sel = task_rec.relative_deadline;
      POL_FIFO: key_sel = task_rec.job_seq;
      default:  key_sel = task_rec.deadline_tick;
    endcase
  end

  assign key        = KEY_WIDTH'(key_sel);
  assign task_stall = busy;
  assign accept     = task_valid && !task_stall;
  // drop records once the store is full
  assign room       = (task_count < CNT_W'(MAX_TASKS));
  assign wr_en      = accept && room;
  assign start      = accept && task_rec.last_task;
  assign n_tasks    = room ? (task_count + CNT_W'(1)) : task_count;

  assign rank_cfg.dynamic = (policy == POL_FIFO) || (policy == POL_EDF);
  assign rank_cfg.levels  = priority_levels;
  assign rank_cfg.idle    = idle_priority;

  always_comb begin
    task_count_next = task_count;
    if (start) begin
      task_count_next = '0;
    end else if (wr_en) begin
      task_count_next = task_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
    end else begin
      task_count <= task_count_next;
    end
  end

  rpr_ram #(
    .WIDTH (KEY_WIDTH + 1),
    .DEPTH (MAX_TASKS)
  ) u_task_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (task_count[IDX_W-1:0]),
    .wdata ({task_rec.task_ready, key}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rpr_ranker #(
    .MAX_TASKS (MAX_TASKS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ranker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .n_tasks   (n_tasks),
    .cfg_in    (rank_cfg),
    .busy      (busy),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (rank_valid),
    .res_stall (rank_stall),
    .res       (rank_res)
  );

endmodule

// File: hw/rtl/rpr_checker.sv
// ---------------------------------------------------------------------------
// rpr_checker
// Port-level checks on the priority ranker, bound to the top level.
// ---------------------------------------------------------------------------
`include "rt_priority_ranker_defines.svh"

module rpr_checker import rpr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  task_valid,
  input logic                  task_stall,
  input task_rec_t             task_rec,
  input logic                  rank_valid,
  input logic                  rank_stall,
  input rank_res_t             rank_res,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic [IDLE_W-1:0] idle_sh;
  logic              seen, prev_last;
  logic [TIDX_W-1:0] prev_idx;

  // shadow the idle register and the last result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_sh <= IDLE_RST;
      seen    <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_IDLE) begin
        idle_sh <= cfg_data[IDLE_W-1:0];
      end
      if (rank_valid && !rank_stall) begin
        seen      <= 1'b1;
        prev_idx  <= rank_res.task_index;
        prev_last <= rank_res.last_result;
      end
    end
  end

  `RPR_ASSERT_NXT(a_res_hold, clk, rst, rank_valid && rank_stall,
    rank_valid && $stable(rank_res), "stalled result changed")
  `RPR_ASSERT_NXT(a_close_stalls, clk, rst, task_valid && !task_stall && task_rec.last_task,
    task_stall, "request taken during rank pass")
  `RPR_ASSERT_IMP(a_prio_floor, clk, rst, rank_valid,
    (rank_res.priority_res > idle_sh) || (rank_res.priority_res == 8'hFF),
    "priority below idle floor")
  `RPR_ASSERT_IMP(a_index_order, clk, rst, rank_valid && seen,
    rank_res.task_index == (prev_last ? 4'd0 : prev_idx + 4'd1),
    "task index out of order")

endmodule

bind rt_priority_ranker rpr_checker u_rpr_checker (.*);
